>>> rtl/vsf_pkg.sv
// Shared types and constants of the VISCA-over-IP sequence framer.
`default_nettype none

package vsf_pkg;

	localparam logic [1:0] FN_SEND    = 2'd0;
	localparam logic [1:0] FN_RECEIVE = 2'd1;
	localparam logic [1:0] FN_RESET   = 2'd2;

	localparam logic REG_CAMERA_ADDRESS    = 1'b0;
	localparam logic REG_NO_SEQUENCE_QUIRK = 1'b1;

	typedef enum logic [3:0] {
		ST_FRAMED          = 4'd0,
		ST_RAW             = 4'd1,
		ST_ACCEPTED        = 4'd2,
		ST_FOREIGN         = 4'd3,
		ST_SHORT           = 4'd4,
		ST_OUT_OF_SEQUENCE = 4'd5,
		ST_RESET           = 4'd6,
		ST_REFRESH         = 4'd7,
		ST_UNKNOWN         = 4'd8,
		ST_LENGTH_ERROR    = 4'd9
	} status_t;

	localparam logic [15:0] TYPE_COMMAND_REPLY = 16'h0111;
	localparam logic [15:0] TYPE_CONTROL       = 16'h0200;
	localparam logic [15:0] TYPE_CONTROL_REPLY = 16'h0201;
	localparam logic [2:0]  CODE_ACK           = 3'b100;
	localparam logic [7:0]  INQUIRY_BYTE       = 8'h09;
	localparam logic [7:0]  TYPE_INQUIRY       = 8'h10;
	localparam logic [7:0]  TYPE_COMMAND       = 8'h00;
	localparam logic [7:0]  FRAME_VERSION      = 8'h01;
	localparam logic [7:0]  CTRL_CLEAR_B0      = 8'h0f;
	localparam logic [7:0]  CTRL_CLEAR_B1      = 8'h01;
	localparam logic [7:0]  CTRL_REFRESH_B0    = 8'h01;
	localparam logic [63:0] RESET_HEADER       = 64'h0200000100000000;
	localparam logic [16:0] MIN_DATAGRAM       = 17'd10;
	localparam logic [16:0] HEADER_LENGTH      = 17'd8;
	localparam logic [15:0] MIN_SEND_LENGTH    = 16'd2;
	localparam logic [3:0]  HEADER_OFFSET      = 4'd8;

	// Input payload, last field (sender_address) in the lowest bits.
	typedef struct packed {
		logic [7:0]  second_byte;
		logic [7:0]  first_byte;
		logic [31:0] sequence_in;
		logic [15:0] payload_type;
		logic [15:0] item_length;
		logic [31:0] sender_address;
	} item_t;

	typedef struct packed {
		logic        en;
		logic [3:0]  slot;
		logic [31:0] data;
	} slot_wr_t;

	typedef struct packed {
		logic        in_table;
		logic [31:0] value;
	} slot_lookup_t;

endpackage

`default_nettype wire

>>> rtl/visca_ip_sequence_framer_unit.sv
// Top level of the VISCA-over-IP sequence framer: handshakes, decision logic, counter.
`default_nettype none

// Takes one datagram descriptor per cycle while the output is not stalled and gives one
// result per descriptor through the decision-stage and output registers. The reply slot
// entry is read from the slot RAM on the accepting edge; while the descriptor is in the
// decision stage the compare is made, and when it advances the counter update and the
// slot write-back happen and the result moves into the output register. A slot written
// by the previous descriptor is forwarded, so back-to-back replies on one slot need no
// stall. The table clears through per-entry valid bits, so there is no clearing pass
// after reset. Configuration writes are taken at any time and are meant for an idle block.
module visca_ip_sequence_framer_unit #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// sender_address, item_length, payload_type, sequence_in, first_byte, second_byte
	input  wire logic [111:0]  s_tdata,
	// func
	input  wire logic [1:0]    s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// header_word, sequence_out, payload_offset, four zero bits
	output logic      [103:0]  m_tdata,
	// status
	output logic      [3:0]    m_tuser,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_index,
	input  wire logic [31:0]   cfg_data
);

	logic                   accept;
	logic                   advance;
	logic                   s1_valid_q;
	vsf_pkg::item_t         item_s1;
	logic [1:0]             func_s1;
	logic [31:0]            camera_address_q;
	logic                   quirk_q;
	logic [31:0]            counter_q;
	logic                   m_tvalid_q;
	vsf_pkg::status_t       status_q;
	logic [63:0]            header_q;
	logic [31:0]            seq_out_q;
	logic [3:0]             offset_q;

	vsf_pkg::status_t       status_c;
	logic [63:0]            header_c;
	logic [31:0]            seq_out_c;
	logic [3:0]             offset_c;
	logic                   count_c;
	logic                   clear_c;
	vsf_pkg::slot_wr_t      wr_c;
	vsf_pkg::slot_wr_t      slot_wr;
	logic                   table_clear;
	vsf_pkg::slot_lookup_t  lookup;

	logic [31:0]            next_count;
	logic [16:0]            eff_length;
	logic [15:0]            rx_type;
	logic [31:0]            rx_seq;
	logic [3:0]             slot;
	logic                   match;

	assign advance   = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready  = !s1_valid_q || advance;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	vsf_slot_store #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_slot_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_slot    (s_tdata[107:104]),
		.lookup_slot(item_s1.second_byte[3:0]),
		.wr         (slot_wr),
		.clear      (table_clear),
		.lookup     (lookup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_address_q <= '0;
			quirk_q          <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == vsf_pkg::REG_CAMERA_ADDRESS) begin
				camera_address_q <= cfg_data;
			end else begin
				quirk_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= vsf_pkg::item_t'(s_tdata);
			func_s1 <= s_tuser;
		end
	end

	assign next_count = counter_q + 32'd1;
	assign eff_length = {1'b0, item_s1.item_length} + (quirk_q ? vsf_pkg::HEADER_LENGTH : '0);
	assign rx_type    = quirk_q ? vsf_pkg::TYPE_COMMAND_REPLY : item_s1.payload_type;
	assign rx_seq     = quirk_q ? 32'd0 : item_s1.sequence_in;
	assign slot       = item_s1.second_byte[3:0];
	assign match      = (rx_seq == counter_q)
	                 || (slot != 4'd0 && lookup.in_table && rx_seq == lookup.value);

	always_comb begin
		status_c  = vsf_pkg::ST_UNKNOWN;
		header_c  = '0;
		seq_out_c = '0;
		offset_c  = '0;
		count_c   = 1'b0;
		clear_c   = 1'b0;
		wr_c      = '0;
		unique case (func_s1)
			vsf_pkg::FN_SEND: begin
				if (quirk_q) begin
					status_c = vsf_pkg::ST_RAW;
				end else if (item_s1.item_length < vsf_pkg::MIN_SEND_LENGTH) begin
					status_c = vsf_pkg::ST_LENGTH_ERROR;
				end else begin
					status_c  = vsf_pkg::ST_FRAMED;
					count_c   = 1'b1;
					header_c  = {vsf_pkg::FRAME_VERSION,
					             (item_s1.second_byte == vsf_pkg::INQUIRY_BYTE)
					                 ? vsf_pkg::TYPE_INQUIRY : vsf_pkg::TYPE_COMMAND,
					             8'h00, item_s1.item_length[7:0], next_count};
					seq_out_c = next_count;
					offset_c  = vsf_pkg::HEADER_OFFSET;
				end
			end
			vsf_pkg::FN_RECEIVE: begin
				priority if (item_s1.sender_address != camera_address_q) begin
					status_c = vsf_pkg::ST_FOREIGN;
				end else if (eff_length < vsf_pkg::MIN_DATAGRAM) begin
					status_c = vsf_pkg::ST_SHORT;
				end else if (rx_type == vsf_pkg::TYPE_COMMAND_REPLY) begin
					seq_out_c = rx_seq;
					if (!match) begin
						status_c = vsf_pkg::ST_OUT_OF_SEQUENCE;
					end else begin
						status_c = vsf_pkg::ST_ACCEPTED;
						offset_c = quirk_q ? 4'd0 : vsf_pkg::HEADER_OFFSET;
						if (slot != 4'd0 && lookup.in_table) begin
							wr_c.en   = 1'b1;
							wr_c.slot = slot;
							wr_c.data = (item_s1.second_byte[6:4] == vsf_pkg::CODE_ACK)
							            ? counter_q : 32'd0;
						end
					end
				end else if (rx_type == vsf_pkg::TYPE_CONTROL
				          || rx_type == vsf_pkg::TYPE_CONTROL_REPLY) begin
					if (item_s1.first_byte == vsf_pkg::CTRL_CLEAR_B0
					    && item_s1.second_byte == vsf_pkg::CTRL_CLEAR_B1) begin
						status_c = vsf_pkg::ST_RESET;
						clear_c  = 1'b1;
						header_c = vsf_pkg::RESET_HEADER;
						offset_c = vsf_pkg::HEADER_OFFSET;
					end else if (item_s1.first_byte == vsf_pkg::CTRL_REFRESH_B0) begin
						status_c = vsf_pkg::ST_REFRESH;
					end
				end else begin
					status_c = vsf_pkg::ST_UNKNOWN;
				end
			end
			vsf_pkg::FN_RESET: begin
				status_c = vsf_pkg::ST_RESET;
				clear_c  = 1'b1;
				header_c = vsf_pkg::RESET_HEADER;
				offset_c = vsf_pkg::HEADER_OFFSET;
			end
			default: begin
				status_c = vsf_pkg::ST_UNKNOWN;
			end
		endcase
	end

	always_comb begin
		slot_wr    = wr_c;
		slot_wr.en = wr_c.en && advance;
	end
	assign table_clear = clear_c && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (table_clear) begin
			counter_q <= '0;
		end else if (advance && count_c) begin
			counter_q <= next_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_c;
			header_q  <= header_c;
			seq_out_q <= seq_out_c;
			offset_q  <= offset_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {4'd0, offset_q, seq_out_q, header_q};

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && func_s1 == vsf_pkg::FN_SEND && status_c == vsf_pkg::ST_FRAMED)
		|=> (counter_q == $past(counter_q) + 32'd1))
		else $error("framed send did not advance the send counter");

	a_clear_counter: assert property (@(posedge clk) disable iff (!arst_n)
		table_clear |=> (counter_q == 32'd0))
		else $error("table reset left the send counter nonzero");

	a_write_or_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_wr.en && table_clear))
		else $error("slot write and table clear in the same cycle");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with an empty decision stage");

endmodule

`default_nettype wire

>>> rtl/vsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module vsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/vsf_slot_store.sv
// Reply slot table: RAM, per-entry valid bits and write-to-read forwarding.
`default_nettype none

module vsf_slot_store #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [3:0]            rd_slot,
	input  wire logic [3:0]            lookup_slot,
	input  wire vsf_pkg::slot_wr_t     wr,
	input  wire logic                  clear,
	output vsf_pkg::slot_lookup_t      lookup
);

	localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [4:0] SLOTS = 5'(SLOT_COUNT);

	logic [SLOT_COUNT-1:0] valid_q;
	vsf_pkg::slot_wr_t     fwd_q;
	logic [31:0]           rd_data;
	logic [AW-1:0]         lookup_idx;
	logic                  in_table;

	vsf_ram #(
		.WIDTH(32),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr.en),
		.wr_addr(wr.slot[AW-1:0]),
		.wr_data(wr.data),
		.rd_en  (rd_en),
		.rd_addr(rd_slot[AW-1:0]),
		.rd_data(rd_data)
	);

	// The write that lands on the same edge as a read is not seen by that read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd_q   <= '0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.slot[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				fwd_q <= wr;
			end
		end
	end

	assign lookup_idx = lookup_slot[AW-1:0];
	assign in_table   = {1'b0, lookup_slot} < SLOTS;

	always_comb begin
		lookup.in_table = in_table;
		if (fwd_q.en && fwd_q.slot == lookup_slot) begin
			lookup.value = fwd_q.data;
		end else if (in_table && valid_q[lookup_idx]) begin
			lookup.value = rd_data;
		end else begin
			lookup.value = '0;
		end
	end

endmodule

`default_nettype wire
